// ===== rtl/sdp_pkg.sv =====
// Shared widths, codes, reset values and inter-module types of the step/dir generator
package sdp_pkg;

    localparam int OP_W        = 3;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 32;
    localparam int SPEED_W     = 20;
    localparam int INTERVAL_W  = 20;
    localparam int MIN_INT_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam int TICKS_PER_SECOND_DEFAULT = 1000000;

    localparam logic [SPEED_W-1:0]   MAX_SPEED_RESET    = 20'd1000;
    localparam logic [MIN_INT_W-1:0] MIN_INTERVAL_RESET = 16'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_DIR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ENABLE = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_SET_SPEED = 3'd1,
        OP_MOVE_BY   = 3'd2,
        OP_MOVE_TO   = 3'd3,
        OP_STOP      = 3'd4,
        OP_SET_POS   = 3'd5,
        OP_ENABLE    = 3'd6,
        OP_DISABLE   = 3'd7
    } op_t;

    typedef struct packed {
        logic               start;
        logic [SPEED_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [INTERVAL_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== rtl/sdp_if.sv =====
// Command and result channel interfaces of the step/dir generator
interface sdp_cmd_if import sdp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, operation, value, input ready);
    modport sink   (input valid, operation, value, output ready);
endinterface

interface sdp_res_if import sdp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    step_pulse;
    logic                    dir_level;
    logic                    enable_level;
    logic signed [POS_W-1:0] position_now;
    logic                    busy_res;
    logic                    speed_limited;

    modport source (output valid, step_pulse, dir_level, enable_level, position_now,
                    busy_res, speed_limited, input ready);
    modport sink   (input valid, step_pulse, dir_level, enable_level, position_now,
                    busy_res, speed_limited, output ready);
endinterface

// ===== rtl/sdp_divider.sv =====
// Serial restoring divider: tick rate over speed magnitude, one quotient bit a cycle
module sdp_divider import sdp_pkg::*; #(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int DIV_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TICKS_PER_SECOND);

    logic               busy_reg,  busy_next;
    logic               done_reg,  done_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [DIV_W-1:0]   quot_reg,  quot_next;
    logic [SPEED_W-1:0] rem_reg,   rem_next;
    logic [SPEED_W-1:0] div_reg,   div_next;
    logic [SPEED_W:0]   rem_shift;
    logic [SPEED_W:0]   rem_diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        rem_shift = {rem_reg, quot_reg[DIV_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            quot_next = DIVIDEND;
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!rem_diff[SPEED_W])
            begin
                rem_next  = rem_diff[SPEED_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[SPEED_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = INTERVAL_W'(quot_reg);

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("divider did not start");

    a_quot_exact: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (div_reg != '0) |->
            ((64'(quot_reg) * 64'(div_reg)) <= 64'(TICKS_PER_SECOND)) &&
            (((64'(quot_reg) + 64'd1) * 64'(div_reg)) > 64'(TICKS_PER_SECOND)))
        else $error("divider quotient is not the floor");

endmodule

// ===== rtl/step_dir_pulse_generator.sv =====
// Step/direction pulse generator top level: command sequencer, motion state, result register
//
//  channel  dir  handshake     payload
//  cmd      in   valid/ready   operation[2:0], value[31:0] signed
//  res      out  valid/ready   step_pulse, dir_level, enable_level, position_now[31:0],
//                              busy_res, speed_limited
//  cfg      in   cfg_we        cfg_index[1:0], cfg_data[19:0]
//
//  Every command but set speed has its result registered in the cycle after its transfer.
//  Set speed goes through the clamp state and, at nonzero speed, the divide state,
//  where it waits for the quotient of the serial divider.
//  Reset leaves the block idle, moving forward at zero speed and disabled.
//  The result register frees the command side as soon as its result is taken;
//  commands stall while a result waits and during the clamp and divide of a set speed.
module step_dir_pulse_generator import sdp_pkg::*; #(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sdp_cmd_if.sink               cmd,
    sdp_res_if.source             res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_DIV
    } state_t;

    state_t state_reg, state_next;

    logic [SPEED_W-1:0]    max_speed_reg;
    logic [MIN_INT_W-1:0]  min_interval_reg;
    logic                  invert_dir_reg;
    logic                  invert_enable_reg;

    logic [POS_W-1:0]      position_reg,   position_next;
    logic [POS_W-1:0]      target_reg,     target_next;
    logic [POS_W-1:0]      steps_left_reg, steps_left_next;
    logic                  forward_reg,    forward_next;
    logic                  moving_reg,     moving_next;
    logic                  enabled_reg,    enabled_next;
    logic                  timer_reg,      timer_next;
    logic [SPEED_W-1:0]    speed_mag_reg,  speed_mag_next;
    logic [INTERVAL_W-1:0] interval_reg,   interval_next;
    logic [INTERVAL_W-1:0] active_reg,     active_next;
    logic [INTERVAL_W-1:0] tick_count_reg, tick_count_next;
    logic                  neg_reg,        neg_next;
    logic [VALUE_W-1:0]    mag_reg,        mag_next;
    logic                  limited_reg,    limited_next;

    logic                  out_valid_reg,  out_valid_next;
    logic                  out_pulse_reg;
    logic                  out_dir_reg;
    logic                  out_enable_reg;
    logic [POS_W-1:0]      out_position_reg;
    logic                  out_busy_reg;
    logic                  out_limited_reg;

    logic                  cmd_xfer;
    logic                  load_out;
    logic                  pulse;
    op_t                   op;
    logic [VALUE_W-1:0]    val;
    logic [POS_W-1:0]      base;
    logic [POS_W-1:0]      diff_pos;
    logic [POS_W-1:0]      diff_neg;
    logic [INTERVAL_W-1:0] tick_inc;
    logic [INTERVAL_W-1:0] reload;
    logic [SPEED_W-1:0]    clamp;
    logic [INTERVAL_W-1:0] quot_lim;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    sdp_divider #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cmd.ready = (state_reg == ST_IDLE) && (!out_valid_reg || res.ready);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign op        = op_t'(cmd.operation);
    assign val       = cmd.value;

    assign base     = (op == OP_MOVE_TO) ? position_reg : '0;
    assign diff_pos = val - base;
    assign diff_neg = base - val;
    assign tick_inc = tick_count_reg + INTERVAL_W'(1);
    assign reload   = (active_reg != '0) ? active_reg : INTERVAL_W'(1);
    assign quot_lim = (div_rsp.quot < INTERVAL_W'(min_interval_reg)) ?
                      INTERVAL_W'(min_interval_reg) : div_rsp.quot;

    always_comb
    begin
        state_next      = state_reg;
        position_next   = position_reg;
        target_next     = target_reg;
        steps_left_next = steps_left_reg;
        forward_next    = forward_reg;
        moving_next     = moving_reg;
        enabled_next    = enabled_reg;
        timer_next      = timer_reg;
        speed_mag_next  = speed_mag_reg;
        interval_next   = interval_reg;
        active_next     = active_reg;
        tick_count_next = tick_count_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        limited_next    = limited_reg;
        load_out        = 1'b0;
        pulse           = 1'b0;
        clamp           = '0;
        div_req.start   = 1'b0;
        div_req.divisor = speed_mag_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    load_out     = 1'b1;
                    limited_next = 1'b0;
                    case (op)
                        OP_TICK:
                        begin
                            if (timer_reg)
                            begin
                                if (tick_inc >= reload)
                                begin
                                    tick_count_next = '0;
                                    if (!moving_reg || steps_left_reg == '0)
                                    begin
                                        timer_next  = 1'b0;
                                        moving_next = 1'b0;
                                    end
                                    else
                                    begin
                                        pulse           = 1'b1;
                                        steps_left_next = steps_left_reg - POS_W'(1);
                                        position_next   = position_reg +
                                                          (forward_reg ? POS_W'(1) : '1);
                                        if (steps_left_reg == POS_W'(1))
                                        begin
                                            timer_next  = 1'b0;
                                            moving_next = 1'b0;
                                        end
                                    end
                                end
                                else
                                begin
                                    tick_count_next = tick_inc;
                                end
                            end
                        end
                        OP_SET_SPEED:
                        begin
                            load_out   = 1'b0;
                            neg_next   = val[VALUE_W-1];
                            mag_next   = val[VALUE_W-1] ? (VALUE_W'(0) - val) : val;
                            state_next = ST_CLAMP;
                        end
                        OP_MOVE_BY, OP_MOVE_TO:
                        begin
                            if (diff_pos != '0)
                            begin
                                if (op == OP_MOVE_TO)
                                begin
                                    target_next = val;
                                end
                                forward_next    = !diff_pos[POS_W-1];
                                steps_left_next = diff_pos[POS_W-1] ? diff_neg : diff_pos;
                                moving_next     = 1'b1;
                                tick_count_next = '0;
                                active_next     = (speed_mag_reg != '0) ? interval_reg :
                                                  INTERVAL_W'(min_interval_reg);
                                timer_next      = 1'b1;
                            end
                        end
                        OP_STOP:
                        begin
                            timer_next      = 1'b0;
                            moving_next     = 1'b0;
                            steps_left_next = '0;
                        end
                        OP_SET_POS:
                        begin
                            position_next = val;
                            target_next   = val;
                        end
                        OP_ENABLE:
                        begin
                            enabled_next = 1'b1;
                        end
                        OP_DISABLE:
                        begin
                            timer_next      = 1'b0;
                            moving_next     = 1'b0;
                            steps_left_next = '0;
                            enabled_next    = 1'b0;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLAMP:
            begin
                if (mag_reg > VALUE_W'(max_speed_reg))
                begin
                    clamp        = max_speed_reg;
                    limited_next = 1'b1;
                end
                else
                begin
                    clamp        = mag_reg[SPEED_W-1:0];
                    limited_next = 1'b0;
                end
                forward_next   = !(neg_reg && clamp != '0);
                speed_mag_next = clamp;
                if (clamp == '0)
                begin
                    interval_next = '1;
                    load_out      = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    div_req.start   = 1'b1;
                    div_req.divisor = clamp;
                    state_next      = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    interval_next = quot_lim;
                    if (moving_reg && !timer_reg)
                    begin
                        tick_count_next = '0;
                        active_next     = quot_lim;
                        timer_next      = 1'b1;
                    end
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = load_out ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            max_speed_reg     <= MAX_SPEED_RESET;
            min_interval_reg  <= MIN_INTERVAL_RESET;
            invert_dir_reg    <= 1'b0;
            invert_enable_reg <= 1'b0;
            position_reg      <= '0;
            target_reg        <= '0;
            steps_left_reg    <= '0;
            forward_reg       <= 1'b1;
            moving_reg        <= 1'b0;
            enabled_reg       <= 1'b0;
            timer_reg         <= 1'b0;
            speed_mag_reg     <= '0;
            interval_reg      <= '0;
            active_reg        <= '0;
            tick_count_reg    <= '0;
            neg_reg           <= 1'b0;
            mag_reg           <= '0;
            limited_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_pulse_reg     <= 1'b0;
            out_dir_reg       <= 1'b0;
            out_enable_reg    <= 1'b0;
            out_position_reg  <= '0;
            out_busy_reg      <= 1'b0;
            out_limited_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            position_reg   <= position_next;
            target_reg     <= target_next;
            steps_left_reg <= steps_left_next;
            forward_reg    <= forward_next;
            moving_reg     <= moving_next;
            enabled_reg    <= enabled_next;
            timer_reg      <= timer_next;
            speed_mag_reg  <= speed_mag_next;
            interval_reg   <= interval_next;
            active_reg     <= active_next;
            tick_count_reg <= tick_count_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
            limited_reg    <= limited_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_SPEED:     max_speed_reg     <= cfg_data[SPEED_W-1:0];
                    CFG_MIN_INTERVAL:  min_interval_reg  <= cfg_data[MIN_INT_W-1:0];
                    CFG_INVERT_DIR:    invert_dir_reg    <= cfg_data[0];
                    CFG_INVERT_ENABLE: invert_enable_reg <= cfg_data[0];
                    default:           max_speed_reg     <= max_speed_reg;
                endcase
            end
            if (load_out)
            begin
                out_pulse_reg    <= pulse;
                out_dir_reg      <= forward_next ^ invert_dir_reg;
                out_enable_reg   <= !enabled_next ^ invert_enable_reg;
                out_position_reg <= position_next;
                out_busy_reg     <= moving_next;
                out_limited_reg  <= limited_next;
            end
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.step_pulse    = out_pulse_reg;
    assign res.dir_level     = out_dir_reg;
    assign res.enable_level  = out_enable_reg;
    assign res.position_now  = out_position_reg;
    assign res.busy_res      = out_busy_reg;
    assign res.speed_limited = out_limited_reg;

    a_timer_moving: assert property (@(posedge clk) disable iff (!rst_n)
        timer_reg |-> moving_reg)
        else $error("step timer running without a move");

    a_moving_steps: assert property (@(posedge clk) disable iff (!rst_n)
        moving_reg |-> (steps_left_reg != '0))
        else $error("move in progress with no steps left");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("quotient arrived outside the divide phase");

endmodule
